FILE: rtl/core/gjk_pkg.sv
// Shared types, codes and saturating vector helpers for the 2D overlap test.
package gjk_pkg;

	localparam int unsigned MAX_ROUNDS_DEF = 32;
	localparam int unsigned QDEPTH         = 2;

	localparam logic [31:0] POS_MAX = 32'h7fffffff;
	localparam logic [31:0] NEG_MAX = 32'h80000000;

	localparam logic KIND_RECT = 1'b0;
	localparam logic KIND_CIRC = 1'b1;

	typedef struct packed {
		logic [31:0] x;
		logic [31:0] y;
	} vec_t;

	typedef struct packed {
		logic        kind;
		vec_t        org;
		logic [30:0] size_a;
		logic [30:0] size_b;
	} shape_t;

	typedef struct packed {
		shape_t first;
		shape_t second;
		vec_t   axis;
	} item_t;

	typedef enum logic {
		SD_SQRT,
		SD_DIV
	} sd_op_t;

	typedef struct packed {
		logic        start;
		sd_op_t      op;
		logic [63:0] arg;
		logic [31:0] divisor;
	} sd_req_t;

	typedef struct packed {
		logic        done;
		logic [31:0] value;
	} sd_rsp_t;

	typedef enum logic [5:0] {
		ST_IDLE, ST_MK0, ST_MK1, ST_MK2, ST_SUP, ST_SQ, ST_SQW,
		ST_MX, ST_MXD, ST_MXW, ST_MY, ST_MYD, ST_MYW,
		ST_DOTX, ST_DOTY, ST_DOTE,
		ST_INIT, ST_TOP, ST_EPS, ST_ADV, ST_ADV2,
		ST_R2A, ST_R2B, ST_R2C,
		ST_R3A, ST_R3B, ST_R3C, ST_R3D, ST_R3E, ST_R3F, ST_R3G,
		ST_NEXT, ST_HIT, ST_MISS
	} eng_state_t;

	function automatic logic signed [33:0] sx34(input logic [31:0] v);
		return $signed({{2{v[31]}}, v});
	endfunction

	function automatic logic [31:0] sat32(input logic signed [33:0] v);
		if (v > 34'sd2147483647) begin
			return POS_MAX;
		end else if (v < -34'sd2147483648) begin
			return NEG_MAX;
		end
		return v[31:0];
	endfunction

	function automatic vec_t vneg(input vec_t a);
		vec_t r;
		r.x = sat32(-sx34(a.x));
		r.y = sat32(-sx34(a.y));
		return r;
	endfunction

	function automatic vec_t vsub(input vec_t a, input vec_t b);
		vec_t r;
		r.x = sat32(sx34(a.x) - sx34(b.x));
		r.y = sat32(sx34(a.y) - sx34(b.y));
		return r;
	endfunction

	function automatic vec_t vperp(input vec_t a);
		vec_t r;
		r.x = sat32(-sx34(a.y));
		r.y = a.x;
		return r;
	endfunction

	// Corner with the largest projection; ties go to the negative side.
	function automatic vec_t rect_pt(input shape_t s, input vec_t d);
		vec_t                r;
		logic signed [33:0] hx;
		logic signed [33:0] hy;
		hx = $signed({4'b0, s.size_a[30:1]});
		hy = $signed({4'b0, s.size_b[30:1]});
		r.x = sat32(sx34(s.org.x) + ((!d.x[31] && d.x != '0) ? hx : -hx));
		r.y = sat32(sx34(s.org.y) + ((!d.y[31] && d.y != '0) ? hy : -hy));
		return r;
	endfunction

	function automatic logic [32:0] mag33(input logic [31:0] v);
		logic [32:0] t;
		t = {v[31], v};
		return v[31] ? (~t + 33'd1) : t;
	endfunction

	function automatic logic [31:0] circ_pt(input logic [31:0] org, input logic neg,
		input logic [31:0] q);
		logic signed [33:0] off;
		off = $signed({2'b0, q});
		return sat32(sx34(org) + (neg ? -off : off));
	endfunction

endpackage

FILE: rtl/core/gjk_front.sv
// Front part: accepts queries and holds them in a short queue for the engine.
module gjk_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  gjk_pkg::item_t item,
	output logic           q_valid,
	output gjk_pkg::item_t head,
	input  logic           pop
);

	localparam int unsigned PW = (gjk_pkg::QDEPTH > 1) ? $clog2(gjk_pkg::QDEPTH) : 1;
	localparam int unsigned CW = $clog2(gjk_pkg::QDEPTH + 1);

	gjk_pkg::item_t slot_q [gjk_pkg::QDEPTH];
	logic [PW-1:0]  wp_q;
	logic [PW-1:0]  rp_q;
	logic [CW-1:0]  cnt_q;
	logic           push;

	assign busy    = (cnt_q == CW'(gjk_pkg::QDEPTH));
	assign push    = start && !busy;
	assign q_valid = (cnt_q != '0);
	assign head    = slot_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wp_q] <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= (wp_q == PW'(gjk_pkg::QDEPTH - 1)) ? '0 : wp_q + PW'(1);
			end
			if (pop) begin
				rp_q <= (rp_q == PW'(gjk_pkg::QDEPTH - 1)) ? '0 : rp_q + PW'(1);
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + CW'(1);
				2'b01:   cnt_q <= cnt_q - CW'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

FILE: rtl/core/gjk_sqdiv.sv
// Shared iterative unit: 64-bit floor square root or 64/32 division, 32 steps.
module gjk_sqdiv (
	input  logic             clk,
	input  logic             arst_n,
	input  gjk_pkg::sd_req_t req,
	output gjk_pkg::sd_rsp_t rsp
);

	gjk_pkg::sd_op_t op_q;
	logic [63:0]     sh_q;
	logic [34:0]     rem_q;
	logic [31:0]     res_q;
	logic [31:0]     d_q;
	logic [5:0]      cnt_q;
	logic            done_q;
	logic [34:0]     rn;
	logic [34:0]     trial;
	logic            ge;

	always_comb begin
		if (op_q == gjk_pkg::SD_SQRT) begin
			rn    = {rem_q[32:0], sh_q[63:62]};
			trial = {1'b0, res_q, 2'b01};
		end else begin
			rn    = {rem_q[33:0], sh_q[63]};
			trial = {3'b0, d_q};
		end
		ge = (rn >= trial);
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			op_q  <= req.op;
			d_q   <= req.divisor;
			res_q <= '0;
			if (req.op == gjk_pkg::SD_SQRT) begin
				rem_q <= '0;
				sh_q  <= req.arg;
			end else begin
				rem_q <= {3'b0, req.arg[63:32]};
				sh_q  <= {req.arg[31:0], 32'b0};
			end
		end else if (cnt_q != '0) begin
			rem_q <= ge ? (rn - trial) : rn;
			res_q <= {res_q[30:0], ge};
			sh_q  <= (op_q == gjk_pkg::SD_SQRT) ? {sh_q[61:0], 2'b0} : {sh_q[62:0], 1'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				cnt_q <= 6'd32;
			end else if (cnt_q != '0) begin
				cnt_q  <= cnt_q - 6'd1;
				done_q <= (cnt_q == 6'd1);
			end
		end
	end

	assign rsp.done  = done_q;
	assign rsp.value = res_q;

endmodule

FILE: rtl/core/gjk_engine.sv
// Back part: sequencer running support, dot-sign and simplex reduction steps.
module gjk_engine #(
	parameter int unsigned MAX_ROUNDS = gjk_pkg::MAX_ROUNDS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           q_valid,
	input  gjk_pkg::item_t head,
	output logic           pop,
	output logic           done,
	output logic           overlap,
	output gjk_pkg::vec_t  vtx0,
	output gjk_pkg::vec_t  vtx1,
	output gjk_pkg::vec_t  vtx2
);

	localparam int unsigned RW = $clog2(MAX_ROUNDS + 1);

	gjk_pkg::eng_state_t state_q, state_d;
	gjk_pkg::eng_state_t mink_ret_q, sup_ret_q, dot_ret_q;

	gjk_pkg::shape_t p_q, q_q, shp;
	gjk_pkg::vec_t   axis_q, a_q, s0_q, s1_q, s2_q, l1_q, l2_q;
	gjk_pkg::vec_t   va_q, vb_q, dv_q, sp_q, spa_q;
	gjk_pkg::vec_t   ab2, a02, ab3, ac3, a03, pab3, pac3;
	logic            sup_sel_q;
	logic [1:0]      n_q;
	logic [RW-1:0]   r_q;
	logic [31:0]     len_q;

	logic signed [32:0] mul_a, mul_b;
	logic signed [65:0] mul_q;
	logic signed [64:0] acc_q, dot_q;
	logic               d_pos, d_neg, d_le1;

	gjk_pkg::sd_req_t sd_req;
	gjk_pkg::sd_rsp_t sd_rsp;

	logic            done_q, ovl_q;
	gjk_pkg::vec_t   t0_q, t1_q, t2_q;

	gjk_sqdiv u_sqdiv (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (sd_req),
		.rsp    (sd_rsp)
	);

	assign shp   = sup_sel_q ? q_q : p_q;
	assign d_pos = !dot_q[64] && (dot_q != '0);
	assign d_neg = dot_q[64];
	assign d_le1 = !dot_q[64] && (dot_q <= 65'sd1);

	assign ab2  = gjk_pkg::vsub(s0_q, s1_q);
	assign a02  = gjk_pkg::vneg(s1_q);
	assign ab3  = gjk_pkg::vsub(s1_q, s2_q);
	assign ac3  = gjk_pkg::vsub(s0_q, s2_q);
	assign a03  = gjk_pkg::vneg(s2_q);
	assign pab3 = gjk_pkg::vperp(ab3);
	assign pac3 = gjk_pkg::vperp(ac3);

	// shared multiplier, registered
	always_ff @(posedge clk) begin
		mul_q <= mul_a * mul_b;
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			gjk_pkg::ST_IDLE: if (q_valid) begin
				state_d = gjk_pkg::ST_MK0;
			end
			gjk_pkg::ST_MK0:  state_d = gjk_pkg::ST_SUP;
			gjk_pkg::ST_MK1:  state_d = gjk_pkg::ST_SUP;
			gjk_pkg::ST_MK2:  state_d = mink_ret_q;
			gjk_pkg::ST_SUP:  state_d = (shp.kind == gjk_pkg::KIND_CIRC) ? gjk_pkg::ST_DOTX
				: sup_ret_q;
			gjk_pkg::ST_SQ:   state_d = gjk_pkg::ST_SQW;
			gjk_pkg::ST_SQW: if (sd_rsp.done) begin
				state_d = (sd_rsp.value == '0) ? sup_ret_q : gjk_pkg::ST_MX;
			end
			gjk_pkg::ST_MX:   state_d = gjk_pkg::ST_MXD;
			gjk_pkg::ST_MXD:  state_d = gjk_pkg::ST_MXW;
			gjk_pkg::ST_MXW: if (sd_rsp.done) begin
				state_d = gjk_pkg::ST_MY;
			end
			gjk_pkg::ST_MY:   state_d = gjk_pkg::ST_MYD;
			gjk_pkg::ST_MYD:  state_d = gjk_pkg::ST_MYW;
			gjk_pkg::ST_MYW: if (sd_rsp.done) begin
				state_d = sup_ret_q;
			end
			gjk_pkg::ST_DOTX: state_d = gjk_pkg::ST_DOTY;
			gjk_pkg::ST_DOTY: state_d = gjk_pkg::ST_DOTE;
			gjk_pkg::ST_DOTE: state_d = dot_ret_q;
			gjk_pkg::ST_INIT: state_d = gjk_pkg::ST_TOP;
			gjk_pkg::ST_TOP:  state_d = (r_q == RW'(MAX_ROUNDS)) ? gjk_pkg::ST_MISS
				: gjk_pkg::ST_DOTX;
			gjk_pkg::ST_EPS:  state_d = d_le1 ? gjk_pkg::ST_MISS : gjk_pkg::ST_MK0;
			gjk_pkg::ST_ADV:  state_d = gjk_pkg::ST_DOTX;
			gjk_pkg::ST_ADV2: begin
				if (d_neg) begin
					state_d = gjk_pkg::ST_MISS;
				end else begin
					state_d = (n_q == 2'd1) ? gjk_pkg::ST_R2A : gjk_pkg::ST_R3A;
				end
			end
			gjk_pkg::ST_R2A:  state_d = gjk_pkg::ST_DOTX;
			gjk_pkg::ST_R2B:  state_d = d_pos ? gjk_pkg::ST_DOTX : gjk_pkg::ST_NEXT;
			gjk_pkg::ST_R2C:  state_d = gjk_pkg::ST_NEXT;
			gjk_pkg::ST_R3A:  state_d = gjk_pkg::ST_DOTX;
			gjk_pkg::ST_R3B:  state_d = gjk_pkg::ST_DOTX;
			gjk_pkg::ST_R3C:  state_d = gjk_pkg::ST_DOTX;
			gjk_pkg::ST_R3D:  state_d = gjk_pkg::ST_DOTX;
			gjk_pkg::ST_R3E:  state_d = gjk_pkg::ST_NEXT;
			gjk_pkg::ST_R3F:  state_d = d_pos ? gjk_pkg::ST_DOTX : gjk_pkg::ST_HIT;
			gjk_pkg::ST_R3G:  state_d = gjk_pkg::ST_NEXT;
			gjk_pkg::ST_NEXT: state_d = gjk_pkg::ST_TOP;
			gjk_pkg::ST_HIT:  state_d = gjk_pkg::ST_IDLE;
			gjk_pkg::ST_MISS: state_d = gjk_pkg::ST_IDLE;
			default:          state_d = gjk_pkg::ST_IDLE;
		endcase
	end

	// outputs to queue, multiplier and square-root/divide unit
	always_comb begin
		pop            = 1'b0;
		mul_a          = '0;
		mul_b          = '0;
		sd_req.start   = 1'b0;
		sd_req.op      = gjk_pkg::SD_SQRT;
		sd_req.arg     = dot_q[63:0];
		sd_req.divisor = len_q;
		case (state_q)
			gjk_pkg::ST_IDLE: pop = q_valid;
			gjk_pkg::ST_DOTX: begin
				mul_a = $signed({va_q.x[31], va_q.x});
				mul_b = $signed({vb_q.x[31], vb_q.x});
			end
			gjk_pkg::ST_DOTY: begin
				mul_a = $signed({va_q.y[31], va_q.y});
				mul_b = $signed({vb_q.y[31], vb_q.y});
			end
			gjk_pkg::ST_MX: begin
				mul_a = $signed(gjk_pkg::mag33(dv_q.x));
				mul_b = $signed({2'b0, shp.size_a});
			end
			gjk_pkg::ST_MY: begin
				mul_a = $signed(gjk_pkg::mag33(dv_q.y));
				mul_b = $signed({2'b0, shp.size_a});
			end
			gjk_pkg::ST_SQ:   sd_req.start = 1'b1;
			gjk_pkg::ST_MXD, gjk_pkg::ST_MYD: begin
				sd_req.start = 1'b1;
				sd_req.op    = gjk_pkg::SD_DIV;
				sd_req.arg   = mul_q[63:0] + {33'b0, len_q[31:1]};
			end
			default: pop = 1'b0;
		endcase
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			gjk_pkg::ST_IDLE: if (q_valid) begin
				p_q        <= head.first;
				q_q        <= head.second;
				axis_q     <= head.axis;
				mink_ret_q <= gjk_pkg::ST_INIT;
			end
			gjk_pkg::ST_MK0: begin
				sup_sel_q <= 1'b0;
				dv_q      <= axis_q;
				sup_ret_q <= gjk_pkg::ST_MK1;
			end
			gjk_pkg::ST_MK1: begin
				spa_q     <= sp_q;
				sup_sel_q <= 1'b1;
				dv_q      <= gjk_pkg::vneg(axis_q);
				sup_ret_q <= gjk_pkg::ST_MK2;
			end
			gjk_pkg::ST_MK2:  a_q <= gjk_pkg::vsub(spa_q, sp_q);
			gjk_pkg::ST_SUP: begin
				if (shp.kind == gjk_pkg::KIND_CIRC) begin
					va_q      <= dv_q;
					vb_q      <= dv_q;
					dot_ret_q <= gjk_pkg::ST_SQ;
				end else begin
					sp_q <= gjk_pkg::rect_pt(shp, dv_q);
				end
			end
			gjk_pkg::ST_SQW: if (sd_rsp.done) begin
				len_q <= sd_rsp.value;
				sp_q  <= shp.org;
			end
			gjk_pkg::ST_MXW: if (sd_rsp.done) begin
				sp_q.x <= gjk_pkg::circ_pt(shp.org.x, dv_q.x[31], sd_rsp.value);
			end
			gjk_pkg::ST_MYW: if (sd_rsp.done) begin
				sp_q.y <= gjk_pkg::circ_pt(shp.org.y, dv_q.y[31], sd_rsp.value);
			end
			gjk_pkg::ST_DOTY: acc_q <= mul_q[64:0];
			gjk_pkg::ST_DOTE: dot_q <= acc_q + mul_q[64:0];
			gjk_pkg::ST_INIT: begin
				s0_q   <= a_q;
				axis_q <= gjk_pkg::vneg(a_q);
				n_q    <= 2'd1;
				r_q    <= '0;
			end
			gjk_pkg::ST_TOP: begin
				va_q      <= axis_q;
				vb_q      <= axis_q;
				dot_ret_q <= gjk_pkg::ST_EPS;
			end
			gjk_pkg::ST_EPS:  mink_ret_q <= gjk_pkg::ST_ADV;
			gjk_pkg::ST_ADV: begin
				va_q      <= a_q;
				vb_q      <= axis_q;
				dot_ret_q <= gjk_pkg::ST_ADV2;
			end
			gjk_pkg::ST_ADV2: if (!d_neg) begin
				if (n_q == 2'd1) begin
					s1_q <= a_q;
					n_q  <= 2'd2;
				end else begin
					s2_q <= a_q;
					n_q  <= 2'd3;
				end
			end
			gjk_pkg::ST_R2A: begin
				va_q      <= ab2;
				vb_q      <= a02;
				dot_ret_q <= gjk_pkg::ST_R2B;
			end
			gjk_pkg::ST_R2B: begin
				if (d_pos) begin
					l1_q      <= gjk_pkg::vperp(ab2);
					va_q      <= gjk_pkg::vperp(ab2);
					vb_q      <= a02;
					dot_ret_q <= gjk_pkg::ST_R2C;
				end else begin
					s0_q   <= s1_q;
					n_q    <= 2'd1;
					axis_q <= a02;
				end
			end
			gjk_pkg::ST_R2C:  axis_q <= d_neg ? gjk_pkg::vneg(l1_q) : l1_q;
			gjk_pkg::ST_R3A: begin
				va_q      <= pab3;
				vb_q      <= ac3;
				dot_ret_q <= gjk_pkg::ST_R3B;
			end
			gjk_pkg::ST_R3B: begin
				l1_q      <= d_pos ? gjk_pkg::vneg(pab3) : pab3;
				va_q      <= pac3;
				vb_q      <= ab3;
				dot_ret_q <= gjk_pkg::ST_R3C;
			end
			gjk_pkg::ST_R3C: begin
				l2_q      <= d_pos ? gjk_pkg::vneg(pac3) : pac3;
				va_q      <= l1_q;
				vb_q      <= a03;
				dot_ret_q <= gjk_pkg::ST_R3D;
			end
			gjk_pkg::ST_R3D: begin
				va_q      <= d_pos ? ab3 : l2_q;
				vb_q      <= a03;
				dot_ret_q <= d_pos ? gjk_pkg::ST_R3E : gjk_pkg::ST_R3F;
			end
			gjk_pkg::ST_R3E: begin
				s0_q   <= s2_q;
				n_q    <= d_pos ? 2'd2 : 2'd1;
				axis_q <= d_pos ? l1_q : a03;
			end
			gjk_pkg::ST_R3F: begin
				va_q      <= ac3;
				vb_q      <= a03;
				dot_ret_q <= gjk_pkg::ST_R3G;
			end
			gjk_pkg::ST_R3G: begin
				s0_q <= s2_q;
				if (d_pos) begin
					s1_q   <= s0_q;
					n_q    <= 2'd2;
					axis_q <= l2_q;
				end else begin
					n_q    <= 2'd1;
					axis_q <= a03;
				end
			end
			gjk_pkg::ST_NEXT: r_q <= r_q + RW'(1);
			gjk_pkg::ST_HIT: begin
				ovl_q <= 1'b1;
				t0_q  <= s0_q;
				t1_q  <= s1_q;
				t2_q  <= s2_q;
			end
			gjk_pkg::ST_MISS: begin
				ovl_q <= 1'b0;
				t0_q  <= '0;
				t1_q  <= '0;
				t2_q  <= '0;
			end
			default: len_q <= len_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= gjk_pkg::ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == gjk_pkg::ST_HIT) || (state_q == gjk_pkg::ST_MISS);
		end
	end

	assign done    = done_q;
	assign overlap = ovl_q;
	assign vtx0    = t0_q;
	assign vtx1    = t1_q;
	assign vtx2    = t2_q;

endmodule

FILE: rtl/core/gjk_overlap_test_2d.sv
// Top level of the 2D overlap test: queue front end and sequenced back end.
// Each circle support point uses one square root and, for a nonzero length, two
// divides of 32 steps each on the shared unit; at most MAX_ROUNDS rounds. One
// query is worked at a time, up to two more wait in the queue; done pulses for
// one cycle per result.
// Reset clears the queue and the sequencer; result registers are not cleared.
module gjk_overlap_test_2d #(
	parameter int unsigned MAX_ROUNDS = gjk_pkg::MAX_ROUNDS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        first_kind,
	input  logic [31:0] first_x,
	input  logic [31:0] first_y,
	input  logic [30:0] first_size_a,
	input  logic [30:0] first_size_b,
	input  logic        second_kind,
	input  logic [31:0] second_x,
	input  logic [31:0] second_y,
	input  logic [30:0] second_size_a,
	input  logic [30:0] second_size_b,
	input  logic [31:0] start_axis_x,
	input  logic [31:0] start_axis_y,
	output logic        done,
	output logic        overlap,
	output logic [31:0] tri_x0,
	output logic [31:0] tri_y0,
	output logic [31:0] tri_x1,
	output logic [31:0] tri_y1,
	output logic [31:0] tri_x2,
	output logic [31:0] tri_y2
);

	gjk_pkg::item_t item;
	gjk_pkg::item_t head;
	gjk_pkg::vec_t  vtx0, vtx1, vtx2;
	logic           q_valid;
	logic           pop;

	// gather the beat's fields into one queue entry
	assign item.first.kind    = first_kind;
	assign item.first.org.x   = first_x;
	assign item.first.org.y   = first_y;
	assign item.first.size_a  = first_size_a;
	assign item.first.size_b  = first_size_b;
	assign item.second.kind   = second_kind;
	assign item.second.org.x  = second_x;
	assign item.second.org.y  = second_y;
	assign item.second.size_a = second_size_a;
	assign item.second.size_b = second_size_b;
	assign item.axis.x        = start_axis_x;
	assign item.axis.y        = start_axis_y;

	// front: take a beat whenever the queue has room
	gjk_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.item    (item),
		.q_valid (q_valid),
		.head    (head),
		.pop     (pop)
	);

	// back: run the support and simplex loop for the query at the head
	gjk_engine #(
		.MAX_ROUNDS (MAX_ROUNDS)
	) u_engine (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.head    (head),
		.pop     (pop),
		.done    (done),
		.overlap (overlap),
		.vtx0    (vtx0),
		.vtx1    (vtx1),
		.vtx2    (vtx2)
	);

	assign tri_x0 = vtx0.x;
	assign tri_y0 = vtx0.y;
	assign tri_x1 = vtx1.x;
	assign tri_y1 = vtx1.y;
	assign tri_x2 = vtx2.x;
	assign tri_y2 = vtx2.y;

endmodule

FILE: tb/gjk_overlap_test_2d_tb.sv
// Self-checking testbench for the 2D overlap test block: directed and random queries.
`timescale 1ns / 100ps

module gjk_overlap_test_2d_tb;

	localparam int unsigned ROUND_LIMIT = 32;
	localparam longint      CYCLE_LIMIT = 30_000_000;

	// Vector held at full precision; components always stay in the 32-bit range
	typedef struct {
		longint x;
		longint y;
	} pt_t;

	typedef struct packed {
		logic        hit;
		logic [31:0] x0;
		logic [31:0] y0;
		logic [31:0] x1;
		logic [31:0] y1;
		logic [31:0] x2;
		logic [31:0] y2;
	} verdict_t;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	gjk_pkg::item_t item;
	logic done;
	logic overlap;
	logic [31:0] tri_x0, tri_y0, tri_x1, tri_y1, tri_x2, tri_y2;

	verdict_t verdicts_due[$];
	int       fails;
	longint   cycles;

	gjk_overlap_test_2d u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.first_kind   (item.first.kind),
		.first_x      (item.first.org.x),
		.first_y      (item.first.org.y),
		.first_size_a (item.first.size_a),
		.first_size_b (item.first.size_b),
		.second_kind  (item.second.kind),
		.second_x     (item.second.org.x),
		.second_y     (item.second.org.y),
		.second_size_a(item.second.size_a),
		.second_size_b(item.second.size_b),
		.start_axis_x (item.axis.x),
		.start_axis_y (item.axis.y),
		.done         (done),
		.overlap      (overlap),
		.tri_x0       (tri_x0),
		.tri_y0       (tri_y0),
		.tri_x1       (tri_x1),
		.tri_y1       (tri_y1),
		.tri_x2       (tri_x2),
		.tri_y2       (tri_y2)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// ---------------------------------------------------------------
	// Overlap predictor, exact integer arithmetic
	// ---------------------------------------------------------------
	function automatic longint clip32(input longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	function automatic pt_t pdiff(input pt_t a, input pt_t b);
		pt_t r;
		r.x = clip32(a.x - b.x);
		r.y = clip32(a.y - b.y);
		return r;
	endfunction

	function automatic pt_t pflip(input pt_t a);
		pt_t r;
		r.x = clip32(-a.x);
		r.y = clip32(-a.y);
		return r;
	endfunction

	function automatic pt_t pnormal(input pt_t a);
		pt_t r;
		r.x = clip32(-a.y);
		r.y = a.x;
		return r;
	endfunction

	// sign of the dot product, taken without rounding
	function automatic int dot_sign(input pt_t a, input pt_t b);
		longint p1;
		longint p2;
		p1 = a.x * b.x;
		p2 = a.y * b.y;
		if (p1 > -p2) return 1;
		if (p1 < -p2) return -1;
		return 0;
	endfunction

	function automatic longint unsigned len_sq(input pt_t a);
		longint unsigned sx;
		longint unsigned sy;
		sx = a.x * a.x;
		sy = a.y * a.y;
		return sx + sy;
	endfunction

	function automatic longint unsigned root_floor(input longint unsigned v);
		longint unsigned r;
		longint unsigned b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b = b >> 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	// offset along one axis of a circle's extreme point, rounded half up in magnitude
	function automatic longint rim_offset(input longint d, input longint unsigned rad,
		input longint unsigned len);
		longint unsigned mag;
		longint          q;
		mag = (d < 0) ? -d : d;
		q = (mag * rad + len / 2) / len;
		return (d < 0) ? -q : q;
	endfunction

	function automatic pt_t extreme_pt(input gjk_pkg::shape_t s, input pt_t d);
		pt_t             r;
		pt_t             o;
		longint unsigned len;
		longint          hx, hy, best, p;
		longint          cx[4];
		longint          cy[4];
		int              k;
		o.x = longint'($signed(s.org.x));
		o.y = longint'($signed(s.org.y));
		r = o;
		if (s.kind == gjk_pkg::KIND_CIRC) begin
			len = root_floor(len_sq(d));
			if (len != 0) begin
				r.x = clip32(o.x + rim_offset(d.x, s.size_a, len));
				r.y = clip32(o.y + rim_offset(d.y, s.size_a, len));
			end
		end else begin
			hx = s.size_a >> 1;
			hy = s.size_b >> 1;
			cx[0] = -hx; cy[0] = -hy; cx[1] = hx; cy[1] = -hy;
			cx[2] = -hx; cy[2] = hy;  cx[3] = hx; cy[3] = hy;
			k = 0;
			best = d.x * cx[0] + d.y * cy[0];
			for (int i = 1; i < 4; i++) begin
				p = d.x * cx[i] + d.y * cy[i];
				if (p > best) begin
					best = p;
					k = i;
				end
			end
			r.x = clip32(o.x + cx[k]);
			r.y = clip32(o.y + cy[k]);
		end
		return r;
	endfunction

	function automatic pt_t diff_pt(input gjk_pkg::item_t it, input pt_t d);
		return pdiff(extreme_pt(it.first, d), extreme_pt(it.second, pflip(d)));
	endfunction

	function automatic verdict_t predict_overlap(input gjk_pkg::item_t it);
		pt_t      s[4];
		pt_t      ax, a, a0, ab, ac, l1, l2;
		int       n;
		bit       hit;
		verdict_t v;
		for (int i = 0; i < 4; i++) s[i] = '{0, 0};
		ax.x = longint'($signed(it.axis.x));
		ax.y = longint'($signed(it.axis.y));
		n = 1;
		hit = 0;
		a = diff_pt(it, ax);
		s[0] = a;
		ax = pflip(a);
		for (int r = 0; r < ROUND_LIMIT; r++) begin
			a = diff_pt(it, ax);
			if (len_sq(ax) <= 1 || dot_sign(a, ax) < 0) break;
			if (n > 2) break;
			s[n] = a;
			n++;
			if (n == 2) begin
				// line case: keep the segment or fall back to the newest point
				a0 = pflip(s[1]);
				ab = pdiff(s[0], s[1]);
				if (dot_sign(ab, a0) > 0) begin
					ax = pnormal(ab);
					if (dot_sign(ax, a0) < 0) ax = pflip(ax);
				end else begin
					s[0] = s[1];
					n = 1;
					ax = a0;
				end
			end else begin
				// triangle case: test both outer edges at the newest point
				a0 = pflip(s[2]);
				ab = pdiff(s[1], s[2]);
				ac = pdiff(s[0], s[2]);
				l1 = pnormal(ab);
				l2 = pnormal(ac);
				if (dot_sign(l1, ac) > 0) l1 = pflip(l1);
				if (dot_sign(l2, ab) > 0) l2 = pflip(l2);
				if (dot_sign(l1, a0) > 0) begin
					s[0] = s[2];
					if (dot_sign(ab, a0) > 0) begin
						n = 2;
						ax = l1;
					end else begin
						n = 1;
						ax = a0;
					end
				end else if (dot_sign(l2, a0) > 0) begin
					if (dot_sign(ac, a0) > 0) begin
						s[1] = s[0];
						s[0] = s[2];
						n = 2;
						ax = l2;
					end else begin
						s[0] = s[2];
						n = 1;
						ax = a0;
					end
				end else begin
					hit = 1;
					break;
				end
			end
		end
		v = '0;
		v.hit = hit;
		if (hit) begin
			v.x0 = s[0].x[31:0]; v.y0 = s[0].y[31:0];
			v.x1 = s[1].x[31:0]; v.y1 = s[1].y[31:0];
			v.x2 = s[2].x[31:0]; v.y2 = s[2].y[31:0];
		end
		return v;
	endfunction

	// ---------------------------------------------------------------
	// Result checker: every done beat is matched with the oldest prediction
	// ---------------------------------------------------------------
	always @(posedge clk) begin
		verdict_t e;
		if (arst_n && done) begin
			if (verdicts_due.size() == 0) begin
				$error("result beat with no query outstanding");
				fails++;
			end else begin
				e = verdicts_due.pop_front();
				if (overlap !== e.hit) begin
					$error("overlap: expected %0d, got %0d", e.hit, overlap); fails++;
				end
				if (tri_x0 !== e.x0) begin
					$error("tri_x0: expected %h, got %h", e.x0, tri_x0); fails++;
				end
				if (tri_y0 !== e.y0) begin
					$error("tri_y0: expected %h, got %h", e.y0, tri_y0); fails++;
				end
				if (tri_x1 !== e.x1) begin
					$error("tri_x1: expected %h, got %h", e.x1, tri_x1); fails++;
				end
				if (tri_y1 !== e.y1) begin
					$error("tri_y1: expected %h, got %h", e.y1, tri_y1); fails++;
				end
				if (tri_x2 !== e.x2) begin
					$error("tri_x2: expected %h, got %h", e.x2, tri_x2); fails++;
				end
				if (tri_y2 !== e.y2) begin
					$error("tri_y2: expected %h, got %h", e.y2, tri_y2); fails++;
				end
			end
		end
	end

	// Watchdog: a hung block must not hang the run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// ---------------------------------------------------------------
	// Stimulus
	// ---------------------------------------------------------------

	// Offer one query, hold it until accepted, then draw the gap before the next.
	// With a zero gap start stays high so back-to-back beats are exercised.
	task automatic send_query(input gjk_pkg::item_t q);
		int gap;
		item  <= q;
		start <= 1'b1;
		@(posedge clk);
		while (busy) @(posedge clk);
		verdicts_due.push_back(predict_overlap(q));
		gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Drop start and hold off until every outstanding result has arrived
	task automatic drain_results();
		start <= 1'b0;
		@(posedge clk);
		while (verdicts_due.size() != 0) @(posedge clk);
	endtask

	function automatic gjk_pkg::shape_t make_shape(input logic k, input int x, input int y,
		input int sa, input int sb);
		gjk_pkg::shape_t s;
		s.kind = k;
		s.org.x = x;
		s.org.y = y;
		s.size_a = sa[30:0];
		s.size_b = sb[30:0];
		return s;
	endfunction

	function automatic gjk_pkg::item_t make_query(input gjk_pkg::shape_t a,
		input gjk_pkg::shape_t b, input int ax, input int ay);
		gjk_pkg::item_t q;
		q.first = a;
		q.second = b;
		q.axis.x = ax;
		q.axis.y = ay;
		return q;
	endfunction

	// Shapes close together so the loop runs several rounds before deciding
	function automatic gjk_pkg::shape_t near_shape(input int spread);
		int sa, sb;
		sa = $urandom_range(0, spread);
		sb = $urandom_range(0, spread);
		return make_shape(1'($urandom_range(0, 1)),
			$signed($urandom_range(0, 2 * spread)) - spread,
			$signed($urandom_range(0, 2 * spread)) - spread, sa, sb);
	endfunction

	function automatic gjk_pkg::item_t wide_query();
		gjk_pkg::item_t q;
		q.first.kind  = 1'($urandom);
		q.first.org   = {$urandom, $urandom};
		q.first.size_a = 31'($urandom);
		q.first.size_b = 31'($urandom);
		q.second.kind = 1'($urandom);
		q.second.org  = {$urandom, $urandom};
		q.second.size_a = 31'($urandom);
		q.second.size_b = 31'($urandom);
		q.axis = {$urandom, $urandom};
		return q;
	endfunction

	task automatic test_directed();
		gjk_pkg::shape_t r0, r1, c0, c1;
		r0 = make_shape(gjk_pkg::KIND_RECT, 0, 0, 32'h0004_0000, 32'h0002_0000);
		r1 = make_shape(gjk_pkg::KIND_RECT, 32'h0001_0000, 32'h0000_8000, 32'h0002_0000,
			32'h0002_0000);
		c0 = make_shape(gjk_pkg::KIND_CIRC, 0, 0, 32'h0001_8000, 0);
		c1 = make_shape(gjk_pkg::KIND_CIRC, 32'h0002_0000, 32'h0001_0000, 32'h0001_0000, 0);
		// overlapping and separated pairs of rectangles and of circles, overlapping mixed pairs
		send_query(make_query(r0, r1, 32'h0001_0000, 0));
		send_query(make_query(r0, make_shape(gjk_pkg::KIND_RECT, 32'h0010_0000, 0,
			32'h0001_0000, 32'h0001_0000), 32'h0001_0000, 0));
		send_query(make_query(c0, c1, 0, 32'h0001_0000));
		send_query(make_query(c0, make_shape(gjk_pkg::KIND_CIRC, 32'h0008_0000, 0,
			32'h0001_0000, 0), 32'hffff_0000, 0));
		send_query(make_query(r0, c1, 32'h0000_1000, 32'hffff_f000));
		send_query(make_query(c1, r1, 1, 1));
		// identical shapes and points with no extent
		send_query(make_query(r0, r0, 32'h0001_0000, 32'h0001_0000));
		send_query(make_query(make_shape(gjk_pkg::KIND_RECT, 5, 5, 0, 0),
			make_shape(gjk_pkg::KIND_RECT, 5, 5, 0, 0), 1, 0));
		send_query(make_query(make_shape(gjk_pkg::KIND_CIRC, 0, 0, 0, 0),
			make_shape(gjk_pkg::KIND_CIRC, 0, 0, 0, 0), 0, 0));
		// zero and tiny start axis, touching edges
		send_query(make_query(r0, r1, 0, 0));
		send_query(make_query(c0, c1, 1, 0));
		send_query(make_query(r0, make_shape(gjk_pkg::KIND_RECT, 32'h0004_0000, 0,
			32'h0004_0000, 32'h0002_0000), 0, 1));
		// extremes: saturating coordinates, largest sizes and axis values
		send_query(make_query(make_shape(gjk_pkg::KIND_RECT, 32'h7fff_ffff, 32'h7fff_ffff,
			32'h7fff_ffff, 32'h7fff_ffff), make_shape(gjk_pkg::KIND_RECT, 32'h8000_0000,
			32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff), 32'h8000_0000, 32'h8000_0000));
		send_query(make_query(make_shape(gjk_pkg::KIND_CIRC, 32'h8000_0000, 32'h7fff_ffff,
			32'h7fff_ffff, 32'h7fff_ffff), make_shape(gjk_pkg::KIND_CIRC, 32'h7fff_ffff,
			32'h8000_0000, 32'h7fff_ffff, 0), 32'h7fff_ffff, 32'h7fff_ffff));
		send_query(make_query(make_shape(gjk_pkg::KIND_CIRC, 0, 0, 32'h7fff_ffff, 0),
			make_shape(gjk_pkg::KIND_RECT, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 0),
			32'h8000_0000, 32'h7fff_ffff));
		send_query(make_query(make_shape(gjk_pkg::KIND_RECT, 32'h8000_0000, 0,
			32'h7fff_ffff, 32'h7fff_ffff), make_shape(gjk_pkg::KIND_CIRC, 32'h7fff_ffff, 0,
			32'h7fff_ffff, 0), 32'h7fff_ffff, 32'h8000_0000));
		send_query(make_query(make_shape(gjk_pkg::KIND_CIRC, 0, 0, 32'h7fff_ffff, 0),
			make_shape(gjk_pkg::KIND_CIRC, 0, 0, 32'h7fff_ffff, 0), 32'h8000_0000, 0));
		send_query(make_query(c0, c1, 32'h7fff_ffff, 1));
	endtask

	// Mostly near shapes at several scales; a share of fully random bits
	task automatic test_random(input int count);
		int spread;
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(0, 7) == 0) begin
				send_query(wide_query());
			end else begin
				case ($urandom_range(0, 2))
					0: spread = 32'h0000_4000;
					1: spread = 32'h0004_0000;
					default: spread = 32'h1000_0000;
				endcase
				send_query(make_query(near_shape(spread), near_shape(spread),
					$signed($urandom_range(0, 2 * spread)) - spread,
					$signed($urandom_range(0, 2 * spread)) - spread));
			end
		end
	endtask

	initial begin
		fails = 0;
		cycles = 0;
		start = 1'b0;
		item = '0;
		arst_n = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		drain_results();
		test_random(360);
		drain_results();
		test_random(370);

		// let the tail settle, then one extra margin for a stray beat
		drain_results();
		repeat (200) @(posedge clk);
		if (fails == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
